@@ hdl/utf8d_pkg.sv @@
// utf8d_pkg: shared types and constants for the utf-8 byte stream decoder
// used by utf8d_step and utf8_byte_stream_decoder_top; no dependencies
package utf8d_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] Replacement = 21'h00FFFD;

  // lead byte classes
  localparam logic [7:0] AsciiMask   = 8'h80;
  localparam logic [7:0] Lead2Mask   = 8'hE0;
  localparam logic [7:0] Lead2Code   = 8'hC0;
  localparam logic [7:0] Lead3Mask   = 8'hF0;
  localparam logic [7:0] Lead3Code   = 8'hE0;
  localparam logic [7:0] Lead4Mask   = 8'hF8;
  localparam logic [7:0] Lead4Code   = 8'hF0;
  localparam logic [7:0] ContMask    = 8'hC0;
  localparam logic [7:0] ContCode    = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [2:0] bytes_remaining;
  } in_item_t;

  typedef struct packed {
    logic [CpW-1:0] uni_scalar;
    logic           replaced;
  } out_item_t;

  typedef struct packed {
    logic [1:0]     pending_count;
    logic [CpW-1:0] accumulator;
    logic           skip_to_end;
  } dec_state_t;

  typedef struct packed {
    logic      emit;
    out_item_t item;
  } step_res_t;

endpackage

@@ hdl/utf8d_step.sv @@
// utf8d_step: next-state and result logic for one byte of the stream
// depends on utf8d_pkg
module utf8d_step (
  input  utf8d_pkg::in_item_t   item,
  input  utf8d_pkg::dec_state_t state_cur,
  output utf8d_pkg::dec_state_t state_nxt,
  output utf8d_pkg::step_res_t  res
);

  logic [7:0]                b;
  logic [2:0]                r;
  logic [1:0]                extra;
  logic [6:0]                lead_bits;
  logic                      is_lead;
  logic [utf8d_pkg::CpW-1:0] acc_shift;

  assign b = item.data_byte;

  // clamp remaining count to 1..4
  always_comb begin
    if (item.bytes_remaining == 3'd0) begin
      r = 3'd1;
    end else if (item.bytes_remaining > 3'd4) begin
      r = 3'd4;
    end else begin
      r = item.bytes_remaining;
    end
  end

  assign acc_shift = {state_cur.accumulator[utf8d_pkg::CpW-7:0], b[5:0]};

  always_comb begin
    is_lead   = 1'b1;
    extra     = 2'd0;
    lead_bits = 7'd0;
    priority if ((b & utf8d_pkg::Lead2Mask) == utf8d_pkg::Lead2Code) begin
      extra     = 2'd1;
      lead_bits = {2'b00, b[4:0]};
    end else if ((b & utf8d_pkg::Lead3Mask) == utf8d_pkg::Lead3Code) begin
      extra     = 2'd2;
      lead_bits = {3'b000, b[3:0]};
    end else if ((b & utf8d_pkg::Lead4Mask) == utf8d_pkg::Lead4Code) begin
      extra     = 2'd3;
      lead_bits = {4'b0000, b[2:0]};
    end else begin
      is_lead = 1'b0;
    end
  end

  always_comb begin
    state_nxt           = state_cur;
    res.emit            = 1'b0;
    res.item.uni_scalar = utf8d_pkg::Replacement;
    res.item.replaced   = 1'b1;
    priority if (state_cur.skip_to_end) begin
      if (r == 3'd1) begin
        state_nxt.skip_to_end = 1'b0;
      end
    end else if (state_cur.pending_count != 2'd0) begin
      if ((b & utf8d_pkg::ContMask) == utf8d_pkg::ContCode) begin
        state_nxt.pending_count = state_cur.pending_count - 2'd1;
        if (state_cur.pending_count == 2'd1) begin
          state_nxt.accumulator = '0;
          res.emit              = 1'b1;
          res.item.uni_scalar   = acc_shift;
          res.item.replaced     = 1'b0;
        end else begin
          state_nxt.accumulator = acc_shift;
        end
      end else begin
        // bad continuation: drop the sequence, byte is consumed
        state_nxt.pending_count = 2'd0;
        state_nxt.accumulator   = '0;
        res.emit                = 1'b1;
      end
    end else if ((b & utf8d_pkg::AsciiMask) == 8'h00) begin
      res.emit            = 1'b1;
      res.item.uni_scalar = {13'd0, b};
      res.item.replaced   = 1'b0;
    end else if (!is_lead) begin
      res.emit = 1'b1;
    end else if ({1'b0, extra} >= r) begin
      // truncated sequence: one replacement, swallow the rest
      res.emit = 1'b1;
      if (r > 3'd1) begin
        state_nxt.skip_to_end = 1'b1;
      end
    end else begin
      state_nxt.pending_count = extra;
      state_nxt.accumulator   = {14'd0, lead_bits};
    end
  end

endmodule

@@ hdl/utf8_byte_stream_decoder_top.sv @@
// utf8_byte_stream_decoder_top: utf-8 byte stream decoder, top level
// depends on utf8d_pkg and utf8d_step
//
// usage
//   input channel: one byte per transaction with the count of bytes left in
//   the buffer (this one included, saturated at 4); taken at a rising edge
//   with in_valid high and in_stall low
//   result channel: zero or one code point per input byte, with replaced set
//   when the code point is u+fffd standing for an error; taken at a rising
//   edge with out_valid high and out_stall low
//   path: a taken byte waits in the input register and is decoded into the result
//   register once the result slot is free; its result, if any, is offered from then on
//   throughput: one byte per cycle while out_stall stays low, set by the single
//   input register and single result register; continuation and skipped bytes give no result
//   stall: while the result register is full and stalled, a held input byte
//   stays put and in_stall rises; the input side may still fill an empty
//   input register, so one transaction can sit on each side of the decoder
//   reset: rst_n low clears the valid flags of both registers and the decoder
//   state (no sequence pending, no skip), stall is low after reset
module utf8_byte_stream_decoder_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  utf8d_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output utf8d_pkg::out_item_t out_data
);

  // input register
  logic                  in_vld_r;
  logic                  in_vld_nxt;
  utf8d_pkg::in_item_t   in_item_r;

  // decoder state
  utf8d_pkg::dec_state_t state_r;
  utf8d_pkg::dec_state_t state_nxt;

  // result register
  logic                  out_vld_r;
  logic                  out_vld_nxt;
  utf8d_pkg::out_item_t  out_item_r;

  utf8d_pkg::step_res_t  res;
  logic                  advance;
  logic                  in_take;

  // the held byte moves through the decoder when the result slot is free
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  utf8d_step u_step (
    .item      (in_item_r),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .res       (res)
  );

  always_comb begin
    in_vld_nxt = in_take || (in_vld_r && !advance);
  end

  always_comb begin
    if (advance) begin
      out_vld_nxt = res.emit;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
    if (advance && res.emit) begin
      out_item_r <= res.item;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  // skipping and a pending sequence never coexist
  a_skip_no_pending : assert property (@(posedge clk) disable iff (!rst_n)
    state_r.skip_to_end |-> (state_r.pending_count == 2'd0))
    else $error("skip with pending sequence");

  // accumulator is clear whenever no sequence is pending
  a_acc_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.pending_count == 2'd0) |-> (state_r.accumulator == '0))
    else $error("accumulator not clear while idle");

  // a replacement always carries u+fffd
  a_repl_value : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_item_r.replaced) |-> (out_item_r.uni_scalar == utf8d_pkg::Replacement))
    else $error("replaced result without u+fffd");

  // state only changes when a byte moves through the decoder
  a_state_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("decoder state changed without a byte");

  // stall is only raised while a byte is held
  a_stall_held : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("stall without a held byte");

endmodule

@@ tb/utf8_byte_stream_decoder_top_test.sv @@
// self-checking testbench for utf8_byte_stream_decoder_top: directed edge cases, random
// text buffers, line noise and backpressure, checked against a local decoder model
// depends on utf8d_pkg and the decoder rtl
`timescale 1ns / 100ps

module utf8_byte_stream_decoder_top_test;

  localparam int ClkPeriod  = 8;
  localparam int HoldCycles = 80;   // long receiver hold-off
  localparam int DrainLimit = 4000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  utf8d_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  utf8d_pkg::out_item_t out_data;

  utf8_byte_stream_decoder_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // decoder model state
  logic [1:0]                seq_left;
  logic [utf8d_pkg::CpW-1:0] cp_accum;
  bit                        swallowing;

  utf8d_pkg::out_item_t expected_cps[$];   // code points still owed by the block
  logic [7:0] text_bytes[$];     // buffer being built for the next text transaction run

  int  items_sent;
  int  results_seen;
  int  replacements_seen;
  int  fails;
  int  in_idle_pct;
  int  out_idle_pct;
  bit  hold_req;
  int  hold_count;
  int  drain_cycles;
  utf8d_pkg::out_item_t want;

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // decode one accepted byte; returns 1 when the byte yields a code point
  function automatic bit decode_byte(input utf8d_pkg::in_item_t item,
                                     output utf8d_pkg::out_item_t res);
    logic [7:0]                b;
    logic [2:0]                left;
    logic [1:0]                extra;
    logic [utf8d_pkg::CpW-1:0] lead_bits;
    b    = item.data_byte;
    left = item.bytes_remaining;
    res  = '0;
    // out-of-range counts are clamped to 1..4
    if (left == 3'd0) left = 3'd1;
    if (left > 3'd4) left = 3'd4;
    // swallowing the tail of a truncated buffer: only the last byte ends it
    if (swallowing) begin
      if (left == 3'd1) swallowing = 1'b0;
      return 1'b0;
    end
    // continuation expected: the count is ignored, only the bit pattern matters
    if (seq_left != 2'd0) begin
      if ((b & utf8d_pkg::ContMask) == utf8d_pkg::ContCode) begin
        cp_accum = {cp_accum[utf8d_pkg::CpW-7:0], b[5:0]};
        seq_left = seq_left - 2'd1;
        if (seq_left == 2'd0) begin
          res.uni_scalar = cp_accum;
          res.replaced   = 1'b0;
          cp_accum       = '0;
          return 1'b1;
        end
        return 1'b0;
      end
      // bad continuation: sequence dropped, byte consumed
      seq_left       = 2'd0;
      cp_accum       = '0;
      res.uni_scalar = utf8d_pkg::Replacement;
      res.replaced   = 1'b1;
      return 1'b1;
    end
    if ((b & utf8d_pkg::AsciiMask) == 8'h00) begin
      res.uni_scalar = {{(utf8d_pkg::CpW - 8){1'b0}}, b};
      return 1'b1;
    end else if ((b & utf8d_pkg::Lead2Mask) == utf8d_pkg::Lead2Code) begin
      lead_bits = {{(utf8d_pkg::CpW - 5){1'b0}}, b[4:0]};
      extra     = 2'd1;
    end else if ((b & utf8d_pkg::Lead3Mask) == utf8d_pkg::Lead3Code) begin
      lead_bits = {{(utf8d_pkg::CpW - 4){1'b0}}, b[3:0]};
      extra     = 2'd2;
    end else if ((b & utf8d_pkg::Lead4Mask) == utf8d_pkg::Lead4Code) begin
      lead_bits = {{(utf8d_pkg::CpW - 3){1'b0}}, b[2:0]};
      extra     = 2'd3;
    end else begin
      // stray continuation or 0xf8..0xff as a lead
      res.uni_scalar = utf8d_pkg::Replacement;
      res.replaced   = 1'b1;
      return 1'b1;
    end
    // truncated sequence: one replacement, then swallow whatever is left
    if ({1'b0, extra} >= left) begin
      if (left > 3'd1) swallowing = 1'b1;
      res.uni_scalar = utf8d_pkg::Replacement;
      res.replaced   = 1'b1;
      return 1'b1;
    end
    cp_accum = lead_bits;
    seq_left = extra;
    return 1'b0;
  endfunction

  // offer one byte, hold it until taken, then maybe idle for a burst
  task automatic send_byte(input logic [7:0] b, input logic [2:0] left);
    utf8d_pkg::in_item_t  item;
    utf8d_pkg::out_item_t res;
    item.data_byte       = b;
    item.bytes_remaining = left;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    if (decode_byte(item, res)) expected_cps.push_back(res);
    items_sent++;
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // append a lead byte and continuation bytes of the given length carrying random payload bits
  task automatic push_code_point(input int n_bytes);
    logic [31:0]               rnd;
    logic [utf8d_pkg::CpW-1:0] cp;
    rnd = $urandom;
    cp  = rnd[utf8d_pkg::CpW-1:0];
    case (n_bytes)
      1: begin
        text_bytes.push_back({1'b0, cp[6:0]});
      end
      2: begin
        text_bytes.push_back({3'b110, cp[10:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        text_bytes.push_back({4'b1110, cp[15:12]});
        text_bytes.push_back({2'b10, cp[11:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        text_bytes.push_back({5'b11110, cp[20:18]});
        text_bytes.push_back({2'b10, cp[17:12]});
        text_bytes.push_back({2'b10, cp[11:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // send text_bytes as one buffer, tagging each byte with the count left
  task automatic send_buffer();
    int         n;
    logic [2:0] left;
    n = text_bytes.size();
    for (int i = 0; i < n; i++) begin
      left = (n - i > 4) ? 3'd4 : 3'(n - i);
      // now and then an out-of-range count, which must clamp
      if (left == 3'd4 && $urandom_range(0, 7) == 0) left = 3'($urandom_range(5, 7));
      if (left == 3'd1 && $urandom_range(0, 7) == 0) left = 3'd0;
      send_byte(text_bytes[i], left);
    end
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 20;
      default: return 45;
    endcase
  endfunction

  // one of each lead class, the field extremes and every error path
  task automatic test_edge_cases();
    send_byte(8'h00, 3'd1);                                          // smallest ascii
    send_byte(8'h7f, 3'd4);                                          // largest ascii
    send_byte(8'hc2, 3'd2); send_byte(8'h80, 3'd1);                  // two-byte
    send_byte(8'hdf, 3'd4); send_byte(8'hbf, 3'd3);
    // genuine u+fffd must come out with replaced clear
    send_byte(8'hef, 3'd3); send_byte(8'hbf, 3'd2); send_byte(8'hbd, 3'd1);
    // largest code point; counts on continuations out of range and ignored
    send_byte(8'hf7, 3'd4); send_byte(8'hbf, 3'd7);
    send_byte(8'hbf, 3'd0); send_byte(8'hbf, 3'd5);
    send_byte(8'h80, 3'd1);                                          // stray continuation
    send_byte(8'hff, 3'd4);                                          // invalid lead
    // truncated with bytes left: skip holds through a count of 4, ends on 1
    send_byte(8'he0, 3'd2); send_byte(8'h41, 3'd4); send_byte(8'h42, 3'd1);
    send_byte(8'hc3, 3'd0);                                          // truncated, count 0 as 1
    send_byte(8'hc3, 3'd2); send_byte(8'h41, 3'd1);                  // bad continuation
    send_byte(8'hf0, 3'd3); send_byte(8'h00, 3'd0);                  // skip ended by 0
  endtask

  // mostly well-formed buffers of random text, some cut short or corrupted
  task automatic test_text_buffers(input int n_items, input bit allow_idle);
    int stop_at;
    int len;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      in_idle_pct  = allow_idle ? pick_idle_pct() : 0;
      out_idle_pct = allow_idle ? pick_idle_pct() : 0;
      len = $urandom_range(1, 14);
      text_bytes.delete();
      while (text_bytes.size() < len) push_code_point($urandom_range(1, 4));
      // cutting the tail can leave a truncated sequence at the end
      if ($urandom_range(0, 2) == 0)
        while (text_bytes.size() > len) void'(text_bytes.pop_back());
      if ($urandom_range(0, 6) == 0)
        text_bytes[$urandom_range(0, text_bytes.size() - 1)] = 8'($urandom);
      send_buffer();
    end
  endtask

  // raw random bytes and counts, including the out-of-range ones
  task automatic test_line_noise(input int n_items);
    in_idle_pct  = 15;
    out_idle_pct = 15;
    repeat (n_items) send_byte(8'($urandom), 3'($urandom_range(0, 7)));
  endtask

  // receiver stalls for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_req     = 1'b1;
    repeat (40) send_byte(8'($urandom_range(0, 127)), 3'd4);
    test_text_buffers(20, 1'b0);
  endtask

  // sender pauses until every owed code point has come back
  task automatic test_drain_pause();
    in_idle_pct  = 10;
    out_idle_pct = 30;
    test_text_buffers(20, 1'b0);
    in_valid <= 1'b0;
    while (expected_cps.size() != 0) @(posedge clk);
    test_text_buffers(20, 1'b0);
  endtask

  // result checker: every accepted code point against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cps.size() == 0) begin
        $error("unexpected code point %h (replaced %b)", out_data.uni_scalar,
               out_data.replaced);
        fails++;
      end else begin
        want = expected_cps.pop_front();
        if (out_data.uni_scalar !== want.uni_scalar) begin
          $error("uni_scalar: expected %h, got %h", want.uni_scalar, out_data.uni_scalar);
          fails++;
        end
        if (out_data.replaced !== want.replaced) begin
          $error("replaced: expected %b, got %b", want.replaced, out_data.replaced);
          fails++;
        end
        results_seen++;
        if (want.replaced) replacements_seen++;
      end
    end
  end

  // receiver: random stall bursts, or one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (hold_count = 0; hold_count < HoldCycles; hold_count++) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    seq_left          = 2'd0;
    cp_accum          = '0;
    swallowing        = 1'b0;
    items_sent        = 0;
    results_seen      = 0;
    replacements_seen = 0;
    fails             = 0;
    in_idle_pct       = 0;
    out_idle_pct      = 0;
    hold_req          = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_edge_cases();
    test_text_buffers(560, 1'b1);
    test_line_noise(150);
    test_backpressure();
    test_drain_pause();
    // closing stretch with neither side idling
    test_text_buffers(100, 1'b0);

    in_valid <= 1'b0;
    for (drain_cycles = 0; expected_cps.size() != 0 && drain_cycles < DrainLimit;
         drain_cycles++)
      @(posedge clk);
    // the decoder holds at most one byte and one result, so a short wait catches any stray transaction
    repeat (8) @(posedge clk);
    if (expected_cps.size() != 0) begin
      $error("%0d expected code points never arrived", expected_cps.size());
      fails++;
    end

    $display("decoded %0d bytes into %0d code points, %0d of them replacements,",
             items_sent, results_seen, replacements_seen);
    $display("across edge cases, random text, line noise and a long receiver hold-off");
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/utf8d_pkg.sv
hdl/utf8d_step.sv
hdl/utf8_byte_stream_decoder_top.sv
tb/utf8_byte_stream_decoder_top_test.sv
